// ===== hdl/stt_pkg.sv =====
// Shared types, token codes and keyword table of the source text tokenizer.
package stt_pkg;

    localparam int MAX_COMMENT_DEPTH = 15;
    localparam int DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam int KW_CHARS = 8;
    localparam int KW_COUNT = 28;

    typedef enum logic [3:0] {
        M_IDLE, M_LINE, M_BLOCK, M_IDENT, M_INT, M_FRAC, M_ESIGN,
        M_EFIRST, M_EDIG, M_STRD, M_STRS, M_OP, M_DOT2
    } mode_t;

    localparam logic [6:0] K_LPAREN   = 7'd0;
    localparam logic [6:0] K_RPAREN   = 7'd1;
    localparam logic [6:0] K_LBRACE   = 7'd2;
    localparam logic [6:0] K_RBRACE   = 7'd3;
    localparam logic [6:0] K_LBRACK   = 7'd4;
    localparam logic [6:0] K_RBRACK   = 7'd5;
    localparam logic [6:0] K_COMMA    = 7'd6;
    localparam logic [6:0] K_DOT      = 7'd7;
    localparam logic [6:0] K_COLON    = 7'd8;
    localparam logic [6:0] K_SEMI     = 7'd9;
    localparam logic [6:0] K_PLUS     = 7'd10;
    localparam logic [6:0] K_MINUS    = 7'd11;
    localparam logic [6:0] K_STAR     = 7'd12;
    localparam logic [6:0] K_SLASH    = 7'd13;
    localparam logic [6:0] K_PERCENT  = 7'd14;
    localparam logic [6:0] K_POW      = 7'd15;
    localparam logic [6:0] K_PLUS_EQ  = 7'd16;
    localparam logic [6:0] K_MINUS_EQ = 7'd17;
    localparam logic [6:0] K_STAR_EQ  = 7'd18;
    localparam logic [6:0] K_SLASH_EQ = 7'd19;
    localparam logic [6:0] K_ASSIGN   = 7'd20;
    localparam logic [6:0] K_EQ       = 7'd21;
    localparam logic [6:0] K_NE       = 7'd22;
    localparam logic [6:0] K_GT       = 7'd23;
    localparam logic [6:0] K_GE       = 7'd24;
    localparam logic [6:0] K_LT       = 7'd25;
    localparam logic [6:0] K_LE       = 7'd26;
    localparam logic [6:0] K_ARROW    = 7'd27;
    localparam logic [6:0] K_FATARROW = 7'd28;
    localparam logic [6:0] K_PIPE     = 7'd29;
    localparam logic [6:0] K_QUEST    = 7'd30;
    localparam logic [6:0] K_DOTDOT   = 7'd31;
    localparam logic [6:0] K_ELLIPSIS = 7'd32;
    localparam logic [6:0] K_HASH     = 7'd33;
    localparam logic [6:0] K_IDENT    = 7'd34;
    localparam logic [6:0] K_STRING   = 7'd35;
    localparam logic [6:0] K_INT      = 7'd36;
    localparam logic [6:0] K_FLOAT    = 7'd37;
    localparam logic [6:0] K_KW0      = 7'd38;
    localparam logic [6:0] K_ERROR    = 7'd66;
    localparam logic [6:0] K_EOF      = 7'd67;
    localparam logic [6:0] K_NEWLINE  = 7'd68;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BAD_NUM  = 3'd1;
    localparam logic [2:0] E_UNTERM   = 3'd2;
    localparam logic [2:0] E_UNEXPECT = 3'd3;
    localparam logic [2:0] E_BAR      = 3'd4;
    localparam logic [2:0] E_BANG     = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BSL = 8'h5C;

    typedef struct packed {
        logic [6:0]  kind;
        logic [2:0]  err;
        logic [23:0] start;
        logic [15:0] len;
        logic [19:0] line;
        logic [15:0] col;
    } token_t;

    // The first character of a keyword sits in the top byte, unused bytes are zero.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"let", 40'd0}, {"mut", 40'd0}, {"fn", 48'd0}, {"return", 16'd0},
        {"if", 48'd0}, {"elif", 32'd0}, {"else", 32'd0}, {"for", 40'd0},
        {"while", 24'd0}, {"in", 48'd0}, {"break", 24'd0}, {"continue"},
        {"match", 24'd0}, {"struct", 16'd0}, {"impl", 32'd0}, {"use", 40'd0},
        {"self", 32'd0}, {"true", 32'd0}, {"false", 24'd0}, {"none", 32'd0},
        {"and", 40'd0}, {"or", 48'd0}, {"not", 40'd0}, {"is", 48'd0},
        {"print", 24'd0}, {"spawn", 24'd0}, {"async", 24'd0}, {"await", 24'd0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd3, 4'd2, 4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2,
        4'd5, 4'd8, 4'd5, 4'd6, 4'd4, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4,
        4'd3, 4'd2, 4'd3, 4'd2, 4'd5, 4'd5, 4'd5, 4'd5
    };

endpackage

// ===== hdl/source_text_tokenizer_top.sv =====
// Top level of the source text tokenizer: scan engine and token output stage.
//
// The input channel takes one source byte per word, or an end mark; a zero
// byte also ends the text. The output channel gives one token record per word,
// with m_last_of_run set on the final token that a source word caused.
// The scan engine performs one scanning step per cycle while the output
// register is free: a step consumes lookahead bytes, closes a lexeme,
// changes scan mode or waits for a second byte. The next byte is accepted
// in the same cycle in which the engine finishes with the previous one.
// Closing a lexeme and starting the next are separate steps.
// A token is held in a pending register until the engine knows whether
// another follows from the same byte, then moves to the output register.
// While the receiver stalls, the engine halts once the output register is
// full and s_ready drops. After the end token all further words are accepted
// and dropped until reset. Reset empties the lookahead, sets line and column
// to one and clears the other counters and the valid flags, not the token records.
module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_token_kind,
    output logic [2:0]  m_error_code,
    output logic [23:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [19:0] m_token_line,
    output logic [15:0] m_token_column,
    output logic        m_last_of_run
);

    localparam logic [23:0] POS_MAX  = '1;
    localparam logic [19:0] LINE_MAX = '1;

    function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [1:0] d);
        logic [24:0] s;
        s = {1'b0, a} + 25'(d);
        return s[24] ? POS_MAX : s[23:0];
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [1:0] d);
        logic [16:0] s;
        s = {1'b0, a} + 17'(d);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    mode_t        mode_reg, mode_next, it_mode;
    logic [7:0]   la0_reg, la0_next, it_la0;
    logic [7:0]   la1_reg, la1_next, it_la1;
    logic [1:0]   cnt_reg, cnt_next, it_cnt;
    logic [63:0]  prefix_reg, prefix_next, it_prefix;
    logic [15:0]  len_reg, len_next, it_len;
    logic [23:0]  start_reg, start_next, it_start;
    logic [23:0]  pos_reg, pos_next, it_pos;
    logic [19:0]  line_reg, line_next, it_line;
    logic [15:0]  col_reg, col_next, it_col;
    logic [15:0]  tcol_reg, tcol_next, it_tcol;
    logic [DEPTH_W-1:0] depth_reg, depth_next, it_depth;
    logic         float_reg, float_next, it_float;
    logic         ended_reg, ended_next;
    logic [2:0]   resn_reg, resn_next, it_resn;
    logic         run_reg, run_next;

    token_t       pend_reg, pend_next;
    logic         pend_valid_reg, pend_valid_next;
    logic         pend_last_reg, pend_last_next;
    token_t       out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_last_reg, out_last_next;

    logic [6:0]   kw_kind;
    logic         go, stop, out_free, accept;
    logic         it_emit;
    token_t       it_tok;

    stt_kw_match u_kw (
        .prefix (prefix_reg),
        .len    (len_reg),
        .kind   (kw_kind)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign go = run_reg && out_free;

    // One scanning step on the registered state.
    always_comb begin
        logic [7:0]  c0, c1, f;
        logic        av0, av1, halt, stop_now, col_one, take;
        logic [1:0]  ncons, eff;
        logic [15:0] len_b, col_b;
        logic [6:0]  k;
        logic [2:0]  e;
        logic [DEPTH_W-1:0] d;
        av0 = cnt_reg != 2'd0 || ended_reg;
        av1 = cnt_reg == 2'd2 || ended_reg;
        c0 = (cnt_reg != 2'd0) ? la0_reg : CH_NUL;
        c1 = (cnt_reg == 2'd2) ? la1_reg : CH_NUL;
        f = prefix_reg[63:56];
        stop_now = !av0 || resn_reg >= 3'd4;
        halt = 1'b0;
        col_one = 1'b0;
        take = 1'b0;
        k = K_ERROR;
        e = E_NONE;
        d = '0;
        ncons = 2'd0;
        len_b = len_reg;
        col_b = col_reg;
        it_mode = mode_reg;
        it_prefix = prefix_reg;
        it_start = start_reg;
        it_line = line_reg;
        it_tcol = tcol_reg;
        it_depth = depth_reg;
        it_float = float_reg;
        it_emit = 1'b0;
        it_tok.kind = K_ERROR;
        it_tok.err = E_NONE;
        if (!stop_now) begin
            case (mode_reg)
                M_IDLE: begin
                    if (c0 == " " || c0 == CH_CR || c0 == CH_TAB) begin
                        ncons = 2'd1;
                    end else if ((c0 == "-" || c0 == "{") && !av1) begin
                        halt = 1'b1;
                    end else if (c0 == "-" && c1 == "-") begin
                        it_mode = M_LINE;
                    end else if (c0 == "{" && c1 == "-") begin
                        ncons = 2'd2;
                        it_depth = DEPTH_W'(1);
                        it_mode = M_BLOCK;
                    end else begin
                        it_start = pos_reg;
                        it_tcol = col_reg;
                        len_b = '0;
                        if (c0 == CH_NUL) begin
                            it_emit = 1'b1;
                            it_tok.kind = K_EOF;
                            halt = 1'b1;
                        end else begin
                            ncons = 2'd1;
                            it_emit = 1'b1;
                            case (c0)
                                CH_NL: begin
                                    it_line = (line_reg == LINE_MAX) ? line_reg : line_reg + 20'd1;
                                    col_one = 1'b1;
                                    it_tok.kind = K_NEWLINE;
                                end
                                "(": it_tok.kind = K_LPAREN;
                                ")": it_tok.kind = K_RPAREN;
                                "{": it_tok.kind = K_LBRACE;
                                "}": it_tok.kind = K_RBRACE;
                                "[": it_tok.kind = K_LBRACK;
                                "]": it_tok.kind = K_RBRACK;
                                ",": it_tok.kind = K_COMMA;
                                ":": it_tok.kind = K_COLON;
                                ";": it_tok.kind = K_SEMI;
                                "#": it_tok.kind = K_HASH;
                                "?": it_tok.kind = K_QUEST;
                                "%": it_tok.kind = K_PERCENT;
                                "+", "-", "*", "/", "!", "=", "<", ">", "|", ".": begin
                                    it_emit = 1'b0;
                                    it_prefix = {c0, 56'd0};
                                    it_mode = M_OP;
                                end
                                CH_DQ: begin
                                    it_emit = 1'b0;
                                    it_mode = M_STRD;
                                end
                                CH_SQ: begin
                                    it_emit = 1'b0;
                                    it_mode = M_STRS;
                                end
                                default: begin
                                    if (is_alpha(c0)) begin
                                        it_emit = 1'b0;
                                        it_prefix = {c0, 56'd0};
                                        it_mode = M_IDENT;
                                    end else if (is_digit(c0)) begin
                                        it_emit = 1'b0;
                                        it_float = 1'b0;
                                        it_mode = M_INT;
                                    end else begin
                                        it_tok.err = E_UNEXPECT;
                                    end
                                end
                            endcase
                        end
                    end
                end
                M_LINE: begin
                    if (c0 == CH_NL || c0 == CH_NUL) begin
                        it_mode = M_IDLE;
                    end else begin
                        ncons = 2'd1;
                    end
                end
                M_BLOCK: begin
                    if (c0 == CH_NUL) begin
                        it_mode = M_IDLE;
                    end else if ((c0 == "{" || c0 == "-") && !av1) begin
                        halt = 1'b1;
                    end else if (c0 == "{" && c1 == "-") begin
                        ncons = 2'd2;
                        if (depth_reg < DEPTH_W'(MAX_COMMENT_DEPTH)) begin
                            it_depth = depth_reg + DEPTH_W'(1);
                        end
                    end else if (c0 == "-" && c1 == "}") begin
                        ncons = 2'd2;
                        d = (depth_reg != '0) ? depth_reg - DEPTH_W'(1) : '0;
                        it_depth = d;
                        if (d == '0) begin
                            it_mode = M_IDLE;
                        end
                    end else begin
                        if (c0 == CH_NL) begin
                            it_line = (line_reg == LINE_MAX) ? line_reg : line_reg + 20'd1;
                            col_b = '0;
                        end
                        ncons = 2'd1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c0) || is_digit(c0)) begin
                        if (len_reg < 16'(KW_CHARS)) begin
                            it_prefix[8 * (7 - len_reg[2:0]) +: 8] = c0;
                        end
                        ncons = 2'd1;
                    end else begin
                        it_emit = 1'b1;
                        it_tok.kind = kw_kind;
                        it_mode = M_IDLE;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(c0)) begin
                        ncons = 2'd1;
                    end else if (mode_reg == M_INT && c0 == "." && !av1) begin
                        halt = 1'b1;
                    end else if (mode_reg == M_INT && c0 == "." && is_digit(c1)) begin
                        it_float = 1'b1;
                        ncons = 2'd1;
                        it_mode = M_FRAC;
                    end else if (c0 == "e" || c0 == "E") begin
                        it_float = 1'b1;
                        ncons = 2'd1;
                        it_mode = M_ESIGN;
                    end else begin
                        it_emit = 1'b1;
                        it_tok.kind = float_reg ? K_FLOAT : K_INT;
                        it_mode = M_IDLE;
                    end
                end
                M_ESIGN: begin
                    if (c0 == "+" || c0 == "-") begin
                        ncons = 2'd1;
                    end
                    it_mode = M_EFIRST;
                end
                M_EFIRST: begin
                    if (is_digit(c0)) begin
                        ncons = 2'd1;
                        it_mode = M_EDIG;
                    end else begin
                        it_emit = 1'b1;
                        it_tok.err = E_BAD_NUM;
                        it_mode = M_IDLE;
                    end
                end
                M_EDIG: begin
                    if (is_digit(c0)) begin
                        ncons = 2'd1;
                    end else begin
                        it_emit = 1'b1;
                        it_tok.kind = K_FLOAT;
                        it_mode = M_IDLE;
                    end
                end
                M_STRD, M_STRS: begin
                    if (c0 == CH_NUL) begin
                        it_emit = 1'b1;
                        it_tok.err = E_UNTERM;
                        it_mode = M_IDLE;
                    end else if (c0 == ((mode_reg == M_STRD) ? CH_DQ : CH_SQ)) begin
                        ncons = 2'd1;
                        it_emit = 1'b1;
                        it_tok.kind = K_STRING;
                        it_mode = M_IDLE;
                    end else if (c0 == CH_BSL) begin
                        if (!av1) begin
                            halt = 1'b1;
                        end else begin
                            ncons = (c1 != CH_NUL) ? 2'd2 : 2'd1;
                        end
                    end else begin
                        if (c0 == CH_NL) begin
                            it_line = (line_reg == LINE_MAX) ? line_reg : line_reg + 20'd1;
                            col_b = '0;
                        end
                        ncons = 2'd1;
                    end
                end
                M_OP: begin
                    take = 1'b1;
                    case (f)
                        "+": begin
                            if (c0 == "=") k = K_PLUS_EQ;
                            else begin take = 1'b0; k = K_PLUS; end
                        end
                        "-": begin
                            if (c0 == ">") k = K_ARROW;
                            else if (c0 == "=") k = K_MINUS_EQ;
                            else begin take = 1'b0; k = K_MINUS; end
                        end
                        "*": begin
                            if (c0 == "*") k = K_POW;
                            else if (c0 == "=") k = K_STAR_EQ;
                            else begin take = 1'b0; k = K_STAR; end
                        end
                        "/": begin
                            if (c0 == "=") k = K_SLASH_EQ;
                            else begin take = 1'b0; k = K_SLASH; end
                        end
                        "!": begin
                            if (c0 == "=") k = K_NE;
                            else begin take = 1'b0; e = E_BANG; end
                        end
                        "=": begin
                            if (c0 == "=") k = K_EQ;
                            else if (c0 == ">") k = K_FATARROW;
                            else begin take = 1'b0; k = K_ASSIGN; end
                        end
                        "<": begin
                            if (c0 == "=") k = K_LE;
                            else begin take = 1'b0; k = K_LT; end
                        end
                        ">": begin
                            if (c0 == "=") k = K_GE;
                            else begin take = 1'b0; k = K_GT; end
                        end
                        "|": begin
                            if (c0 == ">") k = K_PIPE;
                            else begin take = 1'b0; e = E_BAR; end
                        end
                        ".": begin
                            if (c0 != ".") begin take = 1'b0; k = K_DOT; end
                        end
                        default: begin
                            take = 1'b0;
                            e = E_BAR;
                        end
                    endcase
                    ncons = take ? 2'd1 : 2'd0;
                    if (f == "." && c0 == ".") begin
                        it_mode = M_DOT2;
                    end else begin
                        it_emit = 1'b1;
                        it_tok.kind = k;
                        it_tok.err = e;
                        it_mode = M_IDLE;
                    end
                end
                M_DOT2: begin
                    it_emit = 1'b1;
                    if (c0 == ".") begin
                        ncons = 2'd1;
                        it_tok.kind = K_ELLIPSIS;
                    end else begin
                        it_tok.kind = K_DOTDOT;
                    end
                    it_mode = M_IDLE;
                end
                default: begin
                    it_mode = M_IDLE;
                end
            endcase
        end
        eff = (ncons > cnt_reg) ? cnt_reg : ncons;
        it_cnt = cnt_reg - eff;
        it_la0 = (eff == 2'd0) ? la0_reg : ((eff == 2'd1) ? la1_reg : CH_NUL);
        it_la1 = (eff == 2'd0) ? la1_reg : CH_NUL;
        it_pos = sat_add24(pos_reg, eff);
        it_len = sat_add16(len_b, eff);
        it_col = col_one ? 16'd1 : sat_add16(col_b, eff);
        it_resn = resn_reg + {2'd0, it_emit};
        it_tok.start = it_start;
        it_tok.len = it_len;
        it_tok.line = it_line;
        it_tok.col = it_tcol;
        stop = stop_now || halt || !(it_cnt != 2'd0 || ended_reg) || it_resn >= 3'd4;
    end

    assign s_ready = !run_reg || (go && stop);
    assign accept = s_valid && s_ready;

    // Scanner state update and intake of the next source word.
    always_comb begin
        mode_next = go ? it_mode : mode_reg;
        la0_next = go ? it_la0 : la0_reg;
        la1_next = go ? it_la1 : la1_reg;
        cnt_next = go ? it_cnt : cnt_reg;
        prefix_next = go ? it_prefix : prefix_reg;
        len_next = go ? it_len : len_reg;
        start_next = go ? it_start : start_reg;
        pos_next = go ? it_pos : pos_reg;
        line_next = go ? it_line : line_reg;
        col_next = go ? it_col : col_reg;
        tcol_next = go ? it_tcol : tcol_reg;
        depth_next = go ? it_depth : depth_reg;
        float_next = go ? it_float : float_reg;
        resn_next = go ? it_resn : resn_reg;
        ended_next = ended_reg;
        run_next = (go && stop) ? 1'b0 : run_reg;
        if (accept && !ended_reg) begin
            resn_next = 3'd0;
            run_next = 1'b1;
            if (s_end_of_text || s_char_byte == CH_NUL) begin
                ended_next = 1'b1;
            end else if (cnt_next == 2'd0) begin
                la0_next = s_char_byte;
                cnt_next = 2'd1;
            end else if (cnt_next == 2'd1) begin
                la1_next = s_char_byte;
                cnt_next = 2'd2;
            end
        end
    end

    // Pending token and output register.
    always_comb begin
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next = pend_last_reg;
        out_next = out_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (pend_valid_reg && pend_last_reg && out_free) begin
            out_next = pend_reg;
            out_last_next = 1'b1;
            out_valid_next = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (go) begin
            if (it_emit) begin
                if (pend_valid_reg && !pend_last_reg) begin
                    out_next = pend_reg;
                    out_last_next = 1'b0;
                    out_valid_next = 1'b1;
                end
                pend_next = it_tok;
                pend_valid_next = 1'b1;
                pend_last_next = stop;
            end else if (stop && pend_valid_reg && !pend_last_reg) begin
                out_next = pend_reg;
                out_last_next = 1'b1;
                out_valid_next = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            la0_reg <= '0;
            la1_reg <= '0;
            cnt_reg <= '0;
            prefix_reg <= '0;
            len_reg <= '0;
            start_reg <= '0;
            pos_reg <= '0;
            line_reg <= 20'd1;
            col_reg <= 16'd1;
            tcol_reg <= 16'd1;
            depth_reg <= '0;
            float_reg <= 1'b0;
            ended_reg <= 1'b0;
            resn_reg <= '0;
            run_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            la0_reg <= la0_next;
            la1_reg <= la1_next;
            cnt_reg <= cnt_next;
            prefix_reg <= prefix_next;
            len_reg <= len_next;
            start_reg <= start_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            col_reg <= col_next;
            tcol_reg <= tcol_next;
            depth_reg <= depth_next;
            float_reg <= float_next;
            ended_reg <= ended_next;
            resn_reg <= resn_next;
            run_reg <= run_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_token_kind = out_reg.kind;
    assign m_error_code = out_reg.err;
    assign m_token_start = out_reg.start;
    assign m_token_length = out_reg.len;
    assign m_token_line = out_reg.line;
    assign m_token_column = out_reg.col;
    assign m_last_of_run = out_last_reg;

endmodule

// ===== hdl/stt_kw_match.sv =====
// Keyword lookup on the identifier prefix and length.
module stt_kw_match
    import stt_pkg::*;
(
    input  logic [63:0] prefix,
    input  logic [15:0] len,
    output logic [6:0]  kind
);

    always_comb begin
        kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == 16'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
                kind = K_KW0 + 7'(i);
            end
        end
    end

endmodule

// ===== hdl/stt_checker.sv =====
// Port-level checker of the source text tokenizer and its bind statement.
module stt_checker
    import stt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [6:0]  m_token_kind,
    input logic [2:0]  m_error_code,
    input logic [15:0] m_token_length,
    input logic [19:0] m_token_line,
    input logic        m_last_of_run
);

    // A stalled token keeps its kind and run marker.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_last_of_run))
        else $error("stalled token changed");

    // Only error tokens carry an error code.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != K_ERROR |-> m_error_code == E_NONE)
        else $error("error code on a non-error token");

    // The end token is empty and closes its run.
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == K_EOF |-> m_token_length == 16'd0 && m_last_of_run)
        else $error("malformed end token");

    // Line numbers start at one and kinds stay in the defined range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_line != 20'd0 && m_token_kind <= K_NEWLINE)
        else $error("token line or kind out of range");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_error_code   (m_error_code),
    .m_token_length (m_token_length),
    .m_token_line   (m_token_line),
    .m_last_of_run  (m_last_of_run)
);
